// File: rtl/core/range_min_count_segment_tree_assert.svh
// Assertion macros for the range minimum and count tree.
`ifndef RANGE_MIN_COUNT_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MIN_COUNT_SEGMENT_TREE_ASSERT_SVH

`ifndef ASSERT_OFF
`define RMCST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RMCST_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RMCST_ASSERT(label, prop, msg)
`define RMCST_ASSERT_RST(label, prop, msg)
`endif

`endif

// File: rtl/core/rmcst_pkg.sv
// Types and constants shared by the range minimum and count tree.
package rmcst_pkg;

  localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [9:0]         set_index;
    logic signed [31:0] set_value;
    logic [9:0]         range_start;
    logic [10:0]        range_end;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic [10:0]        min_count;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_Q_LO,
    ST_Q_HI
  } state_e;

endpackage

// File: rtl/core/rmcst_ram.sv
// Generic single write port, single read port RAM with registered read data.
module rmcst_ram #(
  parameter int WIDTH = 43,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/range_min_count_segment_tree.sv
// Top level of the range minimum and count segment tree.
//
//   channel  | direction | handshake                  | payload
//   command  | in        | start, busy                | cmd_i   (rmcst_pkg::cmd_t)
//   result   | out       | result_valid_o (strobe)    | result_o (rmcst_pkg::res_t)
//
// A set writes the leaf, then for each tree level reads the sibling through the single
// read port of the node memory and writes the parent.
// Each level of a query costs two read slots.
// After reset a clearing pass initializes nodes 1 to 2*LEAVES - 1 of the node memory.
// busy is high during the clearing pass and while an item is in progress.
// Results are strobed for one cycle; the receiver cannot stall them.
module range_min_count_segment_tree #(
  parameter int LEAVES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  rmcst_pkg::cmd_t cmd_i,
  output logic          result_valid_o,
  output rmcst_pkg::res_t result_o
);

  import rmcst_pkg::*;

  `include "range_min_count_segment_tree_assert.svh"

  localparam int IW = $clog2(LEAVES);
  localparam int AW = IW + 1;
  localparam int NW = AW + 1;
  localparam int CW = IW + 1;
  localparam int EW = AW + 12;
  localparam int DW = 32 + CW;
  localparam logic [EW-1:0] LeavesExt = EW'(LEAVES);
  localparam logic [CW-1:0] LeavesCnt = CW'(LEAVES);

  state_e state_q, state_d;

  logic [AW-1:0] clr_k_q, clr_k_d;
  logic [AW-1:0] lvl_last_q, lvl_last_d;
  logic [CW-1:0] clr_cnt_q, clr_cnt_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [NW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic          pend_q, pend_d;
  logic signed [31:0] acc_val_q, acc_val_d;
  logic [CW-1:0] acc_cnt_q, acc_cnt_d;
  logic          res_valid_q, res_valid_d;
  res_t          res_q, res_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic signed [31:0] rd_val, mrg_val;
  logic [CW-1:0]      rd_cnt, mrg_cnt;
  logic               m_less, m_eq;

  logic [EW-1:0] start_ext, end_ext, hi_clamp, idx_ext;
  logic [NW-1:0] hi_m1;
  logic [CW+10:0] cnt_wide;

  rmcst_ram #(
    .WIDTH(DW),
    .DEPTH(2 * LEAVES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_val  = rdata[DW-1:CW];
  assign rd_cnt  = rdata[CW-1:0];
  assign m_less  = rd_val < acc_val_q;
  assign m_eq    = rd_val == acc_val_q;
  assign mrg_val = m_less ? rd_val : acc_val_q;
  assign mrg_cnt = m_less ? rd_cnt : (m_eq ? acc_cnt_q + rd_cnt : acc_cnt_q);

  assign start_ext = EW'(cmd_i.range_start);
  assign end_ext   = EW'(cmd_i.range_end);
  assign hi_clamp  = (end_ext > LeavesExt) ? LeavesExt : end_ext;
  assign idx_ext   = EW'(cmd_i.set_index);
  assign hi_m1     = hi_q - NW'(1);
  assign cnt_wide  = {{11{1'b0}}, (pend_q ? mrg_cnt : acc_cnt_q)};

  always_comb begin
    state_d     = state_q;
    clr_k_d     = clr_k_q;
    lvl_last_d  = lvl_last_q;
    clr_cnt_d   = clr_cnt_q;
    cur_d       = cur_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    pend_d      = 1'b0;
    acc_val_d   = acc_val_q;
    acc_cnt_d   = acc_cnt_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    case (state_q)
      ST_CLR: begin
        we    = 1'b1;
        waddr = clr_k_q;
        wdata = {VALUE_MAX, clr_cnt_q};
        if (clr_k_q == lvl_last_q) begin
          clr_cnt_d  = clr_cnt_q >> 1;
          lvl_last_d = {lvl_last_q[AW-2:0], 1'b1};
        end
        if (clr_k_q == {AW{1'b1}}) begin
          state_d = ST_IDLE;
        end else begin
          clr_k_d = clr_k_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (cmd_i.operation == OP_SET) begin
            if (idx_ext < LeavesExt) begin
              we        = 1'b1;
              cur_d     = AW'(idx_ext + LeavesExt);
              waddr     = cur_d;
              wdata     = {cmd_i.set_value, CW'(1)};
              acc_val_d = cmd_i.set_value;
              acc_cnt_d = CW'(1);
              state_d   = ST_SET_RD;
            end
          end else begin
            acc_val_d = VALUE_MAX;
            acc_cnt_d = '0;
            if (start_ext < hi_clamp) begin
              lo_d = NW'(start_ext + LeavesExt);
              hi_d = NW'(hi_clamp + LeavesExt);
            end else begin
              lo_d = '0;
              hi_d = '0;
            end
            state_d = ST_Q_LO;
          end
        end
      end
      ST_SET_RD: begin
        raddr   = cur_q ^ AW'(1);
        state_d = ST_SET_WR;
      end
      ST_SET_WR: begin
        we        = 1'b1;
        waddr     = cur_q >> 1;
        wdata     = {mrg_val, mrg_cnt};
        acc_val_d = mrg_val;
        acc_cnt_d = mrg_cnt;
        cur_d     = cur_q >> 1;
        state_d   = (cur_d == AW'(1)) ? ST_IDLE : ST_SET_RD;
      end
      ST_Q_LO: begin
        if (pend_q) begin
          acc_val_d = mrg_val;
          acc_cnt_d = mrg_cnt;
        end
        if (lo_q < hi_q) begin
          if (lo_q[0]) begin
            raddr  = lo_q[AW-1:0];
            lo_d   = lo_q + NW'(1);
            pend_d = 1'b1;
          end
          state_d = ST_Q_HI;
        end else begin
          res_valid_d     = 1'b1;
          res_d.min_value = pend_q ? mrg_val : acc_val_q;
          res_d.min_count = cnt_wide[10:0];
          state_d         = ST_IDLE;
        end
      end
      ST_Q_HI: begin
        if (pend_q) begin
          acc_val_d = mrg_val;
          acc_cnt_d = mrg_cnt;
        end
        if (hi_q[0]) begin
          raddr  = hi_m1[AW-1:0];
          pend_d = 1'b1;
        end
        lo_d    = lo_q >> 1;
        hi_d    = hi_q >> 1;
        state_d = ST_Q_LO;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_k_q     <= AW'(1);
      lvl_last_q  <= AW'(1);
      clr_cnt_q   <= LeavesCnt;
      cur_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_k_q     <= clr_k_d;
      lvl_last_q  <= lvl_last_d;
      clr_cnt_q   <= clr_cnt_d;
      cur_q       <= cur_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_val_q <= acc_val_d;
    acc_cnt_q <= acc_cnt_d;
    res_q     <= res_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `RMCST_ASSERT(a_res_after_query, result_valid_o |-> $past(state_q == ST_Q_LO), "result without query")
  `RMCST_ASSERT(a_empty_is_max, (result_valid_o && result_o.min_count == 11'd0) |-> (result_o.min_value == VALUE_MAX), "empty result not max")
  `RMCST_ASSERT(a_set_not_root, (state_q == ST_SET_WR) |-> (cur_q != AW'(0) && cur_q != AW'(1)), "set walk above root")
  `RMCST_ASSERT(a_acc_bound, (state_q == ST_Q_LO) |-> (acc_cnt_q <= LeavesCnt), "count above leaf total")
  `RMCST_ASSERT_RST(a_rst_clear, !rst_ni |=> (busy && !result_valid_o), "reset left block ready")

endmodule

// File: dv/range_min_count_segment_tree_tb.sv
// Self-checking testbench for the range minimum and count segment tree.
`timescale 1ns / 100ps

module range_min_count_segment_tree_tb;
  import rmcst_pkg::*;

  localparam int LEAVES = 1024;

  class min_count_mirror;
    localparam int LEAF_COUNT = 1024;

    logic signed [31:0] node_min[1:2*LEAF_COUNT-1];
    logic [10:0]        node_cnt[1:2*LEAF_COUNT-1];
    res_t               awaited_answers[$];
    int unsigned        mismatches;
    int unsigned        strays;
    int unsigned        checked;

    function new();
      for (int i = 0; i < LEAF_COUNT; i++) begin
        node_min[LEAF_COUNT + i] = VALUE_MAX;
        node_cnt[LEAF_COUNT + i] = 11'd1;
      end
      for (int k = LEAF_COUNT - 1; k >= 1; k--) begin
        recombine(k);
      end
      mismatches = 0;
      strays     = 0;
      checked    = 0;
    endfunction

    function void fold_in(inout logic signed [31:0] acc_min, inout logic [10:0] acc_cnt,
                          input logic signed [31:0] v, input logic [10:0] c);
      if (v < acc_min) begin
        acc_min = v;
        acc_cnt = c;
      end else if (v == acc_min) begin
        acc_cnt = acc_cnt + c;
      end
    endfunction

    function void recombine(int k);
      logic signed [31:0] m;
      logic [10:0]        c;
      m = node_min[2*k];
      c = node_cnt[2*k];
      fold_in(m, c, node_min[2*k+1], node_cnt[2*k+1]);
      node_min[k] = m;
      node_cnt[k] = c;
    endfunction

    function void record_command(cmd_t cmd);
      int                 k;
      int                 lo;
      int                 hi;
      res_t               answer;
      logic signed [31:0] m;
      logic [10:0]        c;
      if (cmd.operation == OP_SET) begin
        k = LEAF_COUNT + int'(cmd.set_index);
        node_min[k] = cmd.set_value;
        node_cnt[k] = 11'd1;
        for (k = k / 2; k >= 1; k = k / 2) begin
          recombine(k);
        end
      end else begin
        m  = VALUE_MAX;
        c  = '0;
        lo = int'(cmd.range_start);
        hi = int'(cmd.range_end);
        if (hi > LEAF_COUNT) begin
          hi = LEAF_COUNT;
        end
        if (lo < hi) begin
          lo += LEAF_COUNT;
          hi += LEAF_COUNT;
          while (lo < hi) begin
            if (lo % 2 == 1) begin
              fold_in(m, c, node_min[lo], node_cnt[lo]);
              lo++;
            end
            if (hi % 2 == 1) begin
              hi--;
              fold_in(m, c, node_min[hi], node_cnt[hi]);
            end
            lo = lo / 2;
            hi = hi / 2;
          end
        end
        answer.min_value = m;
        answer.min_count = c;
        awaited_answers.push_back(answer);
      end
    endfunction

    function void check_answer(res_t got);
      res_t want;
      if (awaited_answers.size() == 0) begin
        strays++;
        if (mismatches + strays <= 10) begin
          $display("%0t: unexpected result min_value=%0d min_count=%0d",
                   $realtime, got.min_value, got.min_count);
        end
      end else begin
        want = awaited_answers.pop_front();
        checked++;
        if (got.min_value !== want.min_value || got.min_count !== want.min_count) begin
          mismatches++;
          if (mismatches + strays <= 10) begin
            $display("%0t: mismatch min_value exp=%0d act=%0d, min_count exp=%0d act=%0d",
                     $realtime, want.min_value, got.min_value, want.min_count,
                     got.min_count);
          end
        end
      end
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd_i = '0;
  logic result_valid_o;
  res_t result_o;

  min_count_mirror tree_mirror = new();

  int unsigned idle_pct = 29;
  int unsigned hot_base = 0;
  int unsigned n_sets = 0;
  int unsigned n_queries = 0;
  int unsigned n_empty = 0;
  int unsigned n_clamped = 0;

  range_min_count_segment_tree #(
    .LEAVES(LEAVES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        tree_mirror.check_answer(result_o);
      end
      if (start && !busy) begin
        tree_mirror.record_command(cmd_i);
      end
    end
  end

  function automatic cmd_t mk_set(int unsigned idx, logic signed [31:0] val);
    cmd_t c;
    c           = {$urandom, $urandom};
    c.operation = OP_SET;
    c.set_index = idx[9:0];
    c.set_value = val;
    return c;
  endfunction

  function automatic cmd_t mk_query(int unsigned lo, int unsigned hi);
    cmd_t c;
    c             = {$urandom, $urandom};
    c.operation   = OP_QUERY;
    c.range_start = lo[9:0];
    c.range_end   = hi[10:0];
    return c;
  endfunction

  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) begin
      return int'($urandom_range(8)) - 4;
    end else if (r < 55) begin
      return VALUE_MAX;
    end else if (r < 62) begin
      return 32'sh8000_0000;
    end
    return $urandom;
  endfunction

  function automatic int unsigned pick_position();
    if ($urandom_range(99) < 40) begin
      return hot_base + $urandom_range(15);
    end
    return $urandom_range(LEAVES - 1);
  endfunction

  function automatic cmd_t random_item();
    int unsigned lo;
    int unsigned hi;
    int unsigned r;
    if ($urandom_range(99) < 45) begin
      return mk_set(pick_position(), pick_value());
    end
    lo = pick_position();
    r  = $urandom_range(99);
    if (r < 60) begin
      hi = $urandom_range(LEAVES, lo + 1);
    end else if (r < 75) begin
      hi = lo + $urandom_range(16, 1);
    end else if (r < 85) begin
      hi = $urandom_range(2047, LEAVES + 1);
    end else begin
      hi = $urandom_range(lo);
    end
    return mk_query(lo, hi);
  endfunction

  task automatic send_item(input cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      cmd_i <= {$urandom, $urandom};
      @(negedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do begin
      @(posedge clk_i);
    end while (busy);
    if (c.operation == OP_SET) begin
      n_sets++;
    end else begin
      n_queries++;
      if (c.range_end > LEAVES) begin
        n_clamped++;
      end
      if (c.range_start >= ((c.range_end > LEAVES) ? LEAVES : c.range_end)) begin
        n_empty++;
      end
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tree_mirror.pending() > 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned errors;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: reset contents, extreme values, ties, empty and clamped ranges.
    send_item(mk_query(0, LEAVES));
    send_item(mk_query(0, 2047));
    send_item(mk_query(5, 5));
    send_item(mk_query(1023, 0));
    send_item(mk_query(1023, 2047));
    send_item(mk_set(0, 32'sh8000_0000));
    send_item(mk_set(1023, VALUE_MAX));
    send_item(mk_set(512, -32'sd1));
    send_item(mk_set(511, 32'sd0));
    send_item(mk_set(1, 32'sh8000_0000));
    send_item(mk_query(0, LEAVES));
    send_item(mk_query(0, 2));
    send_item(mk_query(1, 1023));
    send_item(mk_query(511, 513));
    send_item(mk_query(1023, LEAVES));
    send_item(mk_query(0, 1));
    send_item(mk_set(1, 32'sh7FFF_FFFE));
    send_item(mk_query(1, 2047));
    send_item(mk_query(2, LEAVES));
    send_item(mk_set(0, VALUE_MAX));
    send_item(mk_query(0, 1024));
    drain();

    for (int n = 0; n < 800; n++) begin
      if (n % 50 == 0) begin
        hot_base = $urandom_range(LEAVES - 16);
      end
      idle_pct = (n >= 300 && n < 450) ? 0 : 29;
      if (n == 400) begin
        drain();
      end
      send_item(random_item());
    end

    drain();
    repeat (40) @(negedge clk_i);

    errors = tree_mirror.mismatches + tree_mirror.strays + tree_mirror.pending();
    $display("Ran %0d updates and %0d range queries, %0d of them empty and %0d past the end.",
             n_sets, n_queries, n_empty, n_clamped);
    $display("Checked %0d answers; %0d wrong, %0d unexpected, %0d missing.",
             tree_mirror.checked, tree_mirror.mismatches, tree_mirror.strays,
             tree_mirror.pending());
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
